// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a boolean condition holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/skts_pkg.sv =====
// ============================================================================
// skts_pkg
// Types and fixed widths shared by the sorter and its channel interfaces.
// ============================================================================
`timescale 1ns / 1ps

package skts_pkg;

  localparam int KEY_W = 64;
  localparam int TAG_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic        [TAG_W-1:0] tag_t;

endpackage

// ===== rtl/skts_if.sv =====
// ============================================================================
// Sorter channel interfaces
// Valid/ready channels for input words and sorted result words.
// ============================================================================
`timescale 1ns / 1ps

interface skts_in_if;
  logic              valid;
  logic              ready;
  skts_pkg::key_t    key;
  skts_pkg::tag_t    tag;
  logic              batch_end;

  modport source (output valid, key, tag, batch_end, input ready);
  modport sink   (input valid, key, tag, batch_end, output ready);
endinterface

interface skts_out_if;
  logic              valid;
  logic              ready;
  skts_pkg::key_t    sorted_key;
  skts_pkg::tag_t    sorted_tag;
  logic              run_last;
  logic              overflowed;

  modport source (output valid, sorted_key, sorted_tag, run_last, overflowed, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, run_last, overflowed, output ready);
endinterface

// ===== rtl/stable_key_tag_sorter.sv =====
// ============================================================================
// Stable key/tag sorter
// Collects a batch of signed Q32.32 keys with tags and emits them in stable
// ascending key order once the word marked batch_end arrives.
// ============================================================================
//
//   channel   direction  word contents                               handshake
//   -------   ---------  ------------------------------------------  ---------
//   items     in         key, tag, batch_end                         valid/ready
//   results   out        sorted_key, sorted_tag, run_last, overflowed valid/ready
//
// Loading takes one cycle per input word. After batch_end, a single shared
// 64-bit signed comparator ranks each stored entry against all n entries, one
// compare per cycle over the single read port of the key memory. Each entry
// is ranked in turn: the entry read, the key latch, one issued read per
// stored entry, the drain of the read pipeline and the order write.
// Emitting then runs through, for each result word, the order memory read, the
// key memory read, the output register load and the offer of the word, which
// is held while the sink holds ready low. Input ready is low from
// batch_end until the last result word has been taken. Reset is synchronous
// and clears the sequencer, the fill count, the overflow flag and the output
// valid; the memories are not cleared, since only entries written in the
// current batch are read.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stable_key_tag_sorter #(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  skts_in_if.sink    items,
  skts_out_if.source results
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [3:0] S_LOAD   = 4'd0;  // take input words
  localparam logic [3:0] S_RD_I   = 4'd1;  // read entry i
  localparam logic [3:0] S_LD_I   = 4'd2;  // latch key of entry i
  localparam logic [3:0] S_RANK   = 4'd3;  // compare entry i against all entries
  localparam logic [3:0] S_WR_ORD = 4'd4;  // place entry i at its rank
  localparam logic [3:0] S_EM_A   = 4'd5;  // read order memory at position p
  localparam logic [3:0] S_EM_B   = 4'd6;  // read key memory at that entry
  localparam logic [3:0] S_EM_C   = 4'd7;  // load output register
  localparam logic [3:0] S_EM_W   = 4'd8;  // wait for the sink to take the word

  logic [3:0]          state;
  logic [CNT_W-1:0]    fill;       // entries stored in this batch
  logic                ovf;        // a word of this batch was dropped
  logic [IDX_W-1:0]    idx_i;      // entry being ranked
  logic [CNT_W-1:0]    idx_j;      // next entry to read during ranking
  logic [IDX_W-1:0]    cmp_idx;    // entry whose key is on the read port
  logic                cmp_valid;
  logic [IDX_W-1:0]    rank;
  logic [IDX_W-1:0]    pos;        // sorted position being emitted
  skts_pkg::key_t      key_i;

  // Storage: keys and tags by load slot, and slot numbers by sorted position.
  skts_pkg::key_t      key_mem [CAPACITY];
  logic [TAG_BITS-1:0] tag_mem [CAPACITY];
  logic [IDX_W-1:0]    ord_mem [CAPACITY];

  logic [IDX_W-1:0]    rd_addr;
  skts_pkg::key_t      rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic [IDX_W-1:0]    ord_rd;

  // Output register.
  logic                out_valid;
  skts_pkg::key_t      out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic                out_last;
  logic                out_ovf;

  logic                accept;
  logic                store_ok;
  logic                before_i;
  logic                last_pos;
  logic                last_i;

  assign accept   = items.valid && items.ready;
  assign store_ok = fill < CNT_W'(CAPACITY);

  // An entry ranks ahead of entry i when its key is smaller, or when the keys
  // are equal and it was loaded earlier; this is what keeps the sort stable.
  assign before_i = (rd_key < key_i) || ((rd_key == key_i) && (cmp_idx < idx_i));

  assign last_i   = (CNT_W'(idx_i) + CNT_W'(1)) == fill;
  assign last_pos = (CNT_W'(pos) + CNT_W'(1)) == fill;

  always_comb begin
    case (state)
      S_RANK:  rd_addr = idx_j[IDX_W-1:0];
      S_EM_B:  rd_addr = ord_rd;
      default: rd_addr = idx_i;
    endcase
  end

  // Key and tag memory: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      key_mem[fill[IDX_W-1:0]] <= items.key;
      tag_mem[fill[IDX_W-1:0]] <= items.tag[TAG_BITS-1:0];
    end
    rd_key <= key_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

  // Order memory: written with each final rank, read while emitting.
  always_ff @(posedge clk) begin
    if (state == S_WR_ORD) begin
      ord_mem[rank] <= idx_i;
    end
    ord_rd <= ord_mem[pos];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              fill <= fill + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (items.batch_end) begin
              idx_i <= '0;
              state <= S_RD_I;
            end
          end
        end
        S_RD_I: begin
          state <= S_LD_I;
        end
        S_LD_I: begin
          key_i     <= rd_key;
          idx_j     <= '0;
          rank      <= '0;
          cmp_valid <= 1'b0;
          state     <= S_RANK;
        end
        S_RANK: begin
          if (idx_j < fill) begin
            idx_j     <= idx_j + CNT_W'(1);
            cmp_idx   <= idx_j[IDX_W-1:0];
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
            if (!cmp_valid) begin
              state <= S_WR_ORD;
            end
          end
          if (cmp_valid && before_i) begin
            rank <= rank + IDX_W'(1);
          end
        end
        S_WR_ORD: begin
          if (last_i) begin
            pos   <= '0;
            state <= S_EM_A;
          end else begin
            idx_i <= idx_i + IDX_W'(1);
            state <= S_RD_I;
          end
        end
        S_EM_A: begin
          state <= S_EM_B;
        end
        S_EM_B: begin
          state <= S_EM_C;
        end
        S_EM_C: begin
          out_key   <= rd_key;
          out_tag   <= rd_tag;
          out_last  <= last_pos;
          out_ovf   <= ovf;
          out_valid <= 1'b1;
          state     <= S_EM_W;
        end
        S_EM_W: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              fill  <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              pos   <= pos + IDX_W'(1);
              state <= S_EM_A;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign items.ready        = (state == S_LOAD);
  assign results.valid      = out_valid;
  assign results.sorted_key = out_key;
  assign results.sorted_tag = skts_pkg::TAG_W'(out_tag);
  assign results.run_last   = out_last;
  assign results.overflowed = out_ovf;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_no_load_while_emitting, !(items.ready && results.valid),
                 "input ready while a result word is pending")
  `ASSERT_ALWAYS(a_fill_in_range, fill <= CNT_W'(CAPACITY),
                 "fill count beyond capacity")
  `ASSERT_ALWAYS(a_rank_in_batch, (state != S_WR_ORD) || (CNT_W'(rank) < fill),
                 "rank outside the stored batch")
  `ASSERT_NEXT(a_run_end_clears,
               results.valid && results.ready && results.run_last,
               (state == S_LOAD) && (fill == '0) && !ovf,
               "batch state not cleared after the last result word")

endmodule

// ===== tb/sv/testbench.sv =====
// ============================================================================
// Stable key/tag sorter testbench
// Sends batches of signed Q32.32 keys with tags over the items channel and
// checks every sorted result word against a stable insertion sort kept in a
// small scoreboard class. Both channels idle and stall in random bursts.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

  typedef skts_pkg::key_t key_t;
  typedef skts_pkg::tag_t tag_t;

  // Block configuration under test.
  localparam int SORT_CAPACITY = 64;
  localparam int TAG_BITS      = 32;

  // Run length and the cycle budget. The slowest legal run is a few large
  // batches that each need a full sort plus stalled output, which stays far
  // below this limit.
  localparam int TOTAL_WORDS  = 230;
  localparam int CALM_WORDS   = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  localparam key_t KEY_MIN  = {1'b1, {(skts_pkg::KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX  = {1'b0, {(skts_pkg::KEY_W-1){1'b1}}};
  localparam key_t KEY_ONE  = 64'sh0000_0001_0000_0000;
  localparam key_t KEY_MONE = 64'shFFFF_FFFF_0000_0000;
  localparam key_t KEY_HALF = 64'sh0000_0000_8000_0000;
  localparam tag_t TAG_MASK = tag_t'((64'd1 << TAG_BITS) - 64'd1);

  // One expected result word.
  typedef struct {
    key_t key;
    tag_t tag;
    bit   run_last;
    bit   overflowed;
  } sorted_word_t;

  // Scoreboard: holds the current batch exactly as the block stores it and,
  // when a word with batch_end is taken, queues the whole batch in stable
  // ascending key order.
  class sorted_run_board;
    key_t         held_keys[SORT_CAPACITY];
    tag_t         held_tags[SORT_CAPACITY];
    int           held_count;
    bit           dropped_any;
    sorted_word_t due_words[$];
    int           fail_count;

    function new();
      held_count  = 0;
      dropped_any = 0;
      fail_count  = 0;
    endfunction

    function void load_word(key_t key, tag_t tag, bit batch_end);
      int           order[SORT_CAPACITY];
      int           i;
      int           j;
      sorted_word_t w;
      // A full batch drops the word but still honors its batch_end.
      if (held_count < SORT_CAPACITY) begin
        held_keys[held_count] = key;
        held_tags[held_count] = tag & TAG_MASK;
        held_count++;
      end else begin
        dropped_any = 1;
      end
      if (!batch_end) return;
      // Insertion sort on indexes; a strict less-than keeps ties in load order.
      for (i = 0; i < held_count; i++) begin
        j = i;
        while (j > 0 && held_keys[i] < held_keys[order[j-1]]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (i = 0; i < held_count; i++) begin
        w.key        = held_keys[order[i]];
        w.tag        = held_tags[order[i]];
        w.run_last   = (i == held_count - 1);
        w.overflowed = dropped_any;
        due_words.push_back(w);
      end
      held_count  = 0;
      dropped_any = 0;
    endfunction

    function void check_word(key_t key, tag_t tag, bit run_last, bit overflowed);
      sorted_word_t w;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word key=%h tag=%h", $time, key, tag);
        fail_count++;
        return;
      end
      w = due_words.pop_front();
      if (key !== w.key) begin
        $display("%0t: sorted_key expected %h actual %h", $time, w.key, key);
        fail_count++;
      end
      if (tag !== w.tag) begin
        $display("%0t: sorted_tag expected %h actual %h", $time, w.tag, tag);
        fail_count++;
      end
      if (run_last !== w.run_last) begin
        $display("%0t: run_last expected %0d actual %0d", $time, w.run_last, run_last);
        fail_count++;
      end
      if (overflowed !== w.overflowed) begin
        $display("%0t: overflowed expected %0d actual %0d", $time, w.overflowed,
                 overflowed);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  skts_in_if  items_if ();
  skts_out_if results_if ();

  stable_key_tag_sorter #(
    .CAPACITY(SORT_CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if)
  );

  sorted_run_board runs = new();

  // Idling controls shared by the two channel processes. Quiet stretches
  // switch idling off for a whole batch; the calm tail switches it off for good.
  bit sender_quiet;
  bit sink_quiet;
  bit calm;
  int words_sent;
  int cycle_count;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    items_if.valid     = 1'b0;
    items_if.key       = '0;
    items_if.tag       = '0;
    items_if.batch_end = 1'b0;
    results_if.ready   = 1'b0;
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
    calm         = 1'b0;
    words_sent   = 0;
    cycle_count  = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle budget: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d result words still due", $time,
               runs.due_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the block's
  // own updates for that edge land.
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      runs.check_word(results_if.sorted_key, results_if.sorted_tag,
                      results_if.run_last, results_if.overflowed);
    end
  end

  // Result sink. Ready changes only at the falling edge and drops in random
  // bursts, so stalls hit the first, middle and last word of a run.
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && !sink_quiet && $urandom_range(0, 5) == 0) begin
        results_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // Presents one word and holds it until the block takes it. Valid is only
  // raised here and only lowered between words, at a different falling edge,
  // so it never toggles twice within one time step.
  task automatic send_word(key_t key, tag_t tag, bit batch_end);
    @(negedge clk);
    items_if.valid     <= 1'b1;
    items_if.key       <= key;
    items_if.tag       <= tag;
    items_if.batch_end <= batch_end;
    do @(posedge clk); while (!items_if.ready);
    runs.load_word(key, tag, batch_end);
    words_sent++;
  endtask

  // Drops valid for a gap whose length is set by the argument.
  task automatic hold_off(int cycles);
    @(negedge clk);
    items_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Random sender gap after an accepted word, unless idling is off.
  task automatic maybe_gap();
    if (!calm && !sender_quiet && $urandom_range(0, 4) == 0) begin
      hold_off($urandom_range(1, 7));
    end
  endtask

  function automatic key_t pick_key();
    int   mode;
    int   small_val;
    key_t k;
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      // Full range: every key bit sees both values.
      k = {$urandom(), $urandom()};
    end else if (mode <= 5) begin
      // A narrow pool around zero makes plenty of equal keys.
      small_val = $urandom_range(0, 8);
      k = key_t'(small_val - 4);
    end else if (mode == 6) begin
      case ($urandom_range(0, 3))
        0:       k = KEY_MIN;
        1:       k = KEY_MAX;
        2:       k = '0;
        default: k = '1;
      endcase
    end else begin
      // Modest integer part with a random fraction.
      small_val = $urandom_range(0, 200);
      k = {32'(small_val - 100), 32'($urandom())};
    end
    return k;
  endfunction

  function automatic tag_t pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return tag_t'($urandom());
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int batch_index;
    int batch_size;
    int i;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Single-word batches at the key and tag extremes.
    send_word(KEY_MAX, '1, 1'b1);
    send_word(KEY_MIN, '0, 1'b1);

    // Signs, zero, the Q32.32 unit and a pure fraction in scrambled order.
    send_word('0,       32'd0, 1'b0);
    send_word('1,       32'd1, 1'b0);
    send_word(KEY_MAX,  32'd2, 1'b0);
    send_word(KEY_MIN,  32'd3, 1'b0);
    send_word(64'sd1,   32'd4, 1'b0);
    send_word(KEY_ONE,  32'd5, 1'b0);
    send_word(KEY_MONE, 32'd6, 1'b0);
    send_word(KEY_HALF, 32'd7, 1'b1);

    // Repeated keys must leave in the order they were loaded.
    send_word(64'sd5,  32'd10, 1'b0);
    send_word(64'sd5,  32'd11, 1'b0);
    send_word(-64'sd3, 32'd12, 1'b0);
    send_word(64'sd5,  32'd13, 1'b0);
    send_word(-64'sd3, 32'd14, 1'b1);

    // Ties at both ends of the key range.
    send_word(KEY_MAX, 32'hAAAA_AAAA, 1'b0);
    send_word(KEY_MIN, 32'h5555_5555, 1'b0);
    send_word(KEY_MAX, 32'h5555_5555, 1'b0);
    send_word(KEY_MIN, 32'hAAAA_AAAA, 1'b1);

    // Random part: mostly small batches, one that fills the store exactly and
    // one that overruns it, so the dropped words include the batch_end word.
    batch_index = 0;
    while (words_sent < TOTAL_WORDS) begin
      if (batch_index == 2)
        batch_size = SORT_CAPACITY;
      else if (batch_index == 5)
        batch_size = SORT_CAPACITY + 3;
      else if ($urandom_range(0, 7) == 0)
        batch_size = $urandom_range(13, 30);
      else
        batch_size = $urandom_range(1, 12);

      sender_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);

      // Once, let the block drain completely before the next batch starts.
      if (batch_index == 3) begin
        @(negedge clk);
        items_if.valid <= 1'b0;
        while (runs.due_words.size() != 0) @(posedge clk);
        hold_off($urandom_range(5, 20));
      end

      for (i = 0; i < batch_size; i++) begin
        if (words_sent >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;
        send_word(pick_key(), pick_tag(), i == batch_size - 1);
        maybe_gap();
      end
      batch_index++;
    end

    @(negedge clk);
    items_if.valid <= 1'b0;

    // Wait for every queued word, then watch a while for stray extra words.
    while (runs.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (runs.fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
